// ----- design/brob_pkg.sv -----
package brob_pkg;

  // Default bitmap geometry
  localparam int unsigned BROB_MAX_WIDTH  = 128;
  localparam int unsigned BROB_MAX_HEIGHT = 64;

  // Signed coordinate width: covers offsets, clipped bounds and sizes up to 1024
  localparam int unsigned CRD_W = 12;

  // Stream and register port widths
  localparam int unsigned IN_W    = 24;
  localparam int unsigned OUT_W   = 16;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // Dots in one braille cell, and the width of the cell walk counter
  localparam int unsigned CELL_DOTS = 8;
  localparam int unsigned CELL_K_W  = 4;

  typedef enum logic [2:0] {
    OP_WR_DST  = 3'd0,
    OP_WR_SRC  = 3'd1,
    OP_RD_DST  = 3'd2,
    OP_BLIT    = 3'd3,
    OP_RD_CELL = 3'd4
  } brob_op_e;

  typedef enum logic [3:0] {
    ROP_DST  = 4'd0,
    ROP_SRC  = 4'd1,
    ROP_NDST = 4'd2,
    ROP_NSRC = 4'd3,
    ROP_OR   = 4'd4,
    ROP_AND  = 4'd5,
    ROP_XOR  = 4'd6,
    ROP_NOR  = 4'd7,
    ROP_NAND = 4'd8
  } brob_rop_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_BAD_X    = 2'd1,
    STS_BAD_Y    = 2'd2,
    STS_BAD_MODE = 2'd3
  } brob_status_e;

  typedef enum logic [1:0] {
    REG_DST_W = 2'd0,
    REG_DST_H = 2'd1,
    REG_SRC_W = 2'd2,
    REG_SRC_H = 2'd3
  } brob_reg_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_PIX,
    S_RD_WAIT,
    S_CELL,
    S_BLIT_SETUP,
    S_BLIT,
    S_RESULT
  } brob_state_e;

  // One command as it arrives on the input stream, first field highest
  typedef struct packed {
    logic [3:0]        raster_mode;
    logic              pixel_value;
    logic signed [6:0] pos_y;
    logic signed [7:0] pos_x;
    logic [2:0]        opcode;
  } brob_cmd_t;

  localparam int unsigned CMD_W = $bits(brob_cmd_t);

  // Raster op of source bit s and destination bit d
  function automatic logic rop_apply(input logic [3:0] mode, input logic s, input logic d);
    logic r;
    case (brob_rop_e'(mode))
      ROP_DST:  r = d;
      ROP_SRC:  r = s;
      ROP_NDST: r = ~d;
      ROP_NSRC: r = ~s;
      ROP_OR:   r = s | d;
      ROP_AND:  r = s & d;
      ROP_XOR:  r = s ^ d;
      ROP_NOR:  r = ~(s | d);
      default:  r = ~(s & d);
    endcase
    return r;
  endfunction

  // Column offset of each cell dot
  function automatic logic cell_dx(input logic [2:0] k);
    logic r;
    case (k)
      3'd3, 3'd4, 3'd5, 3'd7: r = 1'b1;
      default:                r = 1'b0;
    endcase
    return r;
  endfunction

  // Row offset of each cell dot
  function automatic logic [1:0] cell_dy(input logic [2:0] k);
    logic [1:0] r;
    case (k)
      3'd1, 3'd4: r = 2'd1;
      3'd2, 3'd5: r = 2'd2;
      3'd6, 3'd7: r = 2'd3;
      default:    r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- design/brob_ram.sv -----
module brob_ram #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned AW    = 13
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic          wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic          rdata_o
);

  logic mem_q [DEPTH];
  logic rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/bitmap_raster_op_blitter_top.sv -----
// Each command, including errors, pixel writes, pixel reads, cell reads and blits, yields one
// result beat; a blit walks its clipped area one pixel per cycle through the destination RAM.
// One command at a time: the next is taken in the cycle after the result is loaded.
// Reset is asynchronous, active low; afterwards a clearing pass zeroes all MAX_WIDTH*MAX_HEIGHT
// cells of both bitmaps before the first beat is taken. Config writes work throughout.
module bitmap_raster_op_blitter_top
  import brob_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = BROB_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = BROB_MAX_HEIGHT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // commands
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // opcode[2:0], pos_x[10:3], pos_y[17:11], pixel_value[18], raster_mode[22:19]
  input  logic [IN_W-1:0]    s_axis_tdata,
  // results
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // read_data[7:0], status[9:8]
  output logic [OUT_W-1:0]   m_axis_tdata
);

  localparam int unsigned CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(CELLS);

  localparam logic signed [CRD_W-1:0] C_ZERO  = 0;
  localparam logic signed [CRD_W-1:0] C_ONE   = 1;
  localparam logic signed [CRD_W-1:0] C_THREE = 3;

  // ---------------------------------------------------------------- helpers
  function automatic logic signed [CRD_W-1:0] clamp_dim(input logic [7:0] v,
                                                        input int unsigned maxv);
    logic signed [CRD_W-1:0] r;
    if (v == 8'd0) begin
      r = C_ONE;
    end else if (CRD_W'(v) > CRD_W'(maxv)) begin
      r = CRD_W'(maxv);
    end else begin
      r = CRD_W'(v);
    end
    return r;
  endfunction

  function automatic brob_status_e chk(input logic signed [CRD_W-1:0] x,
                                       input logic signed [CRD_W-1:0] y,
                                       input logic signed [CRD_W-1:0] w,
                                       input logic signed [CRD_W-1:0] h);
    brob_status_e r;
    if (x < C_ZERO || x >= w) begin
      r = STS_BAD_X;
    end else if (y < C_ZERO || y >= h) begin
      r = STS_BAD_Y;
    end else begin
      r = STS_OK;
    end
    return r;
  endfunction

  // base address of a row, modulo the RAM depth
  function automatic logic [AW-1:0] row_addr(input logic signed [CRD_W-1:0] y);
    return AW'(AW'($unsigned(y)) * AW'(MAX_WIDTH));
  endfunction

  function automatic logic [AW-1:0] cell_off(input logic [2:0] k);
    return AW'(AW'(cell_dy(k)) * AW'(MAX_WIDTH) + AW'(cell_dx(k)));
  endfunction

  // ---------------------------------------------------------------- registers
  logic [7:0] cfg_dw_q, cfg_sw_q;
  logic [6:0] cfg_dh_q, cfg_sh_q;

  brob_state_e  state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  brob_cmd_t    cmd_q, cmd_d;
  brob_status_e sts_q, sts_d;
  logic [7:0]   data_q, data_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [CELL_K_W-1:0] k_q, k_d;
  logic signed [CRD_W-1:0] x0_q, x0_d, x1_q, x1_d, y0_q, y0_d, y1_q, y1_d;
  logic signed [CRD_W-1:0] x_q, x_d, y_q, y_d, sx_q, sx_d;
  logic [AW-1:0] drow_q, drow_d, srow_q, srow_d;
  logic          bp_valid_q, bp_valid_d;
  logic [AW-1:0] bp_addr_q, bp_addr_d;
  logic          m_valid_q, m_valid_d;
  logic [OUT_W-1:0] m_data_q, m_data_d;

  // RAM controls
  logic          dst_we, dst_wdata, dst_re, dst_rdata;
  logic [AW-1:0] dst_waddr, dst_raddr;
  logic          src_we, src_wdata, src_re, src_rdata;
  logic [AW-1:0] src_waddr, src_raddr;

  // decode of the held command
  logic signed [CRD_W-1:0] px_s, py_s, dw_s, dh_s, sw_s, sh_s;
  logic signed [CRD_W-1:0] cx0, cx1, cy0, cy1;
  logic signed [CRD_W-1:0] px_end, py_end;
  brob_status_e dec_sts;
  logic         clip_empty;
  logic         cfg_wr;
  logic [2:0]   k_idx;

  // ---------------------------------------------------------------- register port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_dw_q <= 8'd128;
      cfg_dh_q <= 7'd64;
      cfg_sw_q <= 8'd16;
      cfg_sh_q <= 7'd16;
    end else if (cfg_wr) begin
      case (brob_reg_e'(paddr[3:2]))
        REG_DST_W: cfg_dw_q <= pwdata[7:0];
        REG_DST_H: cfg_dh_q <= pwdata[6:0];
        REG_SRC_W: cfg_sw_q <= pwdata[7:0];
        REG_SRC_H: cfg_sh_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (brob_reg_e'(paddr[3:2]))
      REG_DST_W: prdata = PDATA_W'(cfg_dw_q);
      REG_DST_H: prdata = PDATA_W'(cfg_dh_q);
      REG_SRC_W: prdata = PDATA_W'(cfg_sw_q);
      REG_SRC_H: prdata = PDATA_W'(cfg_sh_q);
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- decode
  assign px_s = {{(CRD_W-8){cmd_q.pos_x[7]}}, cmd_q.pos_x};
  assign py_s = {{(CRD_W-7){cmd_q.pos_y[6]}}, cmd_q.pos_y};
  assign dw_s = clamp_dim(cfg_dw_q, MAX_WIDTH);
  assign dh_s = clamp_dim({1'b0, cfg_dh_q}, MAX_HEIGHT);
  assign sw_s = clamp_dim(cfg_sw_q, MAX_WIDTH);
  assign sh_s = clamp_dim({1'b0, cfg_sh_q}, MAX_HEIGHT);

  always_comb begin
    case (brob_op_e'(cmd_q.opcode))
      OP_WR_DST, OP_RD_DST: dec_sts = chk(px_s, py_s, dw_s, dh_s);
      OP_WR_SRC:            dec_sts = chk(px_s, py_s, sw_s, sh_s);
      OP_RD_CELL:           dec_sts = chk(px_s, py_s, dw_s - C_ONE, dh_s - C_THREE);
      OP_BLIT: begin
        if (cmd_q.raster_mode > ROP_NAND) begin
          dec_sts = STS_BAD_MODE;
        end else begin
          dec_sts = STS_OK;
        end
      end
      default:              dec_sts = STS_OK;
    endcase
  end

  // blit rectangle clipped to the destination
  assign px_end     = px_s + sw_s;
  assign py_end     = py_s + sh_s;
  assign cx0        = (px_s < C_ZERO) ? C_ZERO : px_s;
  assign cy0        = (py_s < C_ZERO) ? C_ZERO : py_s;
  assign cx1        = (px_end < dw_s) ? px_end : dw_s;
  assign cy1        = (py_end < dh_s) ? py_end : dh_s;
  assign clip_empty = (cx0 >= cx1) || (cy0 >= cy1);

  assign k_idx = 3'(k_q - CELL_K_W'(1));

  // ---------------------------------------------------------------- control
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    cmd_d      = cmd_q;
    sts_d      = sts_q;
    data_d     = data_q;
    addr_d     = addr_q;
    k_d        = k_q;
    x0_d       = x0_q;
    x1_d       = x1_q;
    y0_d       = y0_q;
    y1_d       = y1_q;
    x_d        = x_q;
    y_d        = y_q;
    sx_d       = sx_q;
    drow_d     = drow_q;
    srow_d     = srow_q;
    bp_valid_d = 1'b0;
    bp_addr_d  = bp_addr_q;
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;

    s_axis_tready = 1'b0;

    // blit write-back: follows the reads in the next cycle
    dst_we    = bp_valid_q;
    dst_waddr = bp_addr_q;
    dst_wdata = rop_apply(cmd_q.raster_mode, src_rdata, dst_rdata);
    dst_re    = 1'b0;
    dst_raddr = addr_q;
    src_we    = 1'b0;
    src_waddr = addr_q;
    src_wdata = cmd_q.pixel_value;
    src_re    = 1'b0;
    src_raddr = srow_q;

    // result beat taken
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        dst_we    = 1'b1;
        dst_waddr = clr_q;
        dst_wdata = 1'b0;
        src_we    = 1'b1;
        src_waddr = clr_q;
        src_wdata = 1'b0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(CELLS - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_d   = brob_cmd_t'(s_axis_tdata[CMD_W-1:0]);
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        sts_d  = dec_sts;
        data_d = '0;
        addr_d = row_addr(py_s) + AW'($unsigned(px_s));
        k_d    = '0;
        x0_d   = cx0;
        x1_d   = cx1;
        y0_d   = cy0;
        y1_d   = cy1;
        if (dec_sts != STS_OK) begin
          state_d = S_RESULT;
        end else begin
          case (brob_op_e'(cmd_q.opcode))
            OP_WR_DST, OP_WR_SRC, OP_RD_DST: state_d = S_PIX;
            OP_RD_CELL:                      state_d = S_CELL;
            OP_BLIT:  state_d = clip_empty ? S_RESULT : S_BLIT_SETUP;
            default:  state_d = S_RESULT;
          endcase
        end
      end

      S_PIX: begin
        state_d = S_RESULT;
        case (brob_op_e'(cmd_q.opcode))
          OP_WR_DST: begin
            dst_we    = 1'b1;
            dst_waddr = addr_q;
            dst_wdata = cmd_q.pixel_value;
          end
          OP_WR_SRC: begin
            src_we = 1'b1;
          end
          OP_RD_DST: begin
            dst_re  = 1'b1;
            state_d = S_RD_WAIT;
          end
          default: ;
        endcase
      end

      S_RD_WAIT: begin
        data_d  = {7'd0, dst_rdata};
        state_d = S_RESULT;
      end

      // issue dot k, collect dot k-1
      S_CELL: begin
        if (k_q != CELL_K_W'(CELL_DOTS)) begin
          dst_re    = 1'b1;
          dst_raddr = addr_q + cell_off(k_q[2:0]);
        end
        if (k_q != '0) begin
          data_d[k_idx] = dst_rdata;
        end
        k_d = k_q + CELL_K_W'(1);
        if (k_q == CELL_K_W'(CELL_DOTS)) begin
          state_d = S_RESULT;
        end
      end

      S_BLIT_SETUP: begin
        drow_d  = row_addr(y0_q);
        srow_d  = row_addr(y0_q - py_s);
        x_d     = x0_q;
        sx_d    = x0_q - px_s;
        y_d     = y0_q;
        state_d = S_BLIT;
      end

      // one pixel per cycle: read both bitmaps, write back next cycle
      S_BLIT: begin
        dst_re     = 1'b1;
        dst_raddr  = drow_q + AW'($unsigned(x_q));
        src_re     = 1'b1;
        src_raddr  = srow_q + AW'($unsigned(sx_q));
        bp_valid_d = 1'b1;
        bp_addr_d  = drow_q + AW'($unsigned(x_q));
        if (x_q + C_ONE == x1_q) begin
          x_d    = x0_q;
          sx_d   = x0_q - px_s;
          y_d    = y_q + C_ONE;
          drow_d = drow_q + AW'(MAX_WIDTH);
          srow_d = srow_q + AW'(MAX_WIDTH);
          if (y_q + C_ONE == y1_q) begin
            state_d = S_RESULT;
          end
        end else begin
          x_d  = x_q + C_ONE;
          sx_d = sx_q + C_ONE;
        end
      end

      S_RESULT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {6'd0, sts_q, data_q};
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      bp_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      bp_valid_q <= bp_valid_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    sts_q     <= sts_d;
    data_q    <= data_d;
    addr_q    <= addr_d;
    k_q       <= k_d;
    x0_q      <= x0_d;
    x1_q      <= x1_d;
    y0_q      <= y0_d;
    y1_q      <= y1_d;
    x_q       <= x_d;
    y_q       <= y_d;
    sx_q      <= sx_d;
    drow_q    <= drow_d;
    srow_q    <= srow_d;
    bp_addr_q <= bp_addr_d;
    m_data_q  <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // ---------------------------------------------------------------- bitmaps
  brob_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_dst_ram (
    .clk_i   (clk_i),
    .we_i    (dst_we),
    .waddr_i (dst_waddr),
    .wdata_i (dst_wdata),
    .re_i    (dst_re),
    .raddr_i (dst_raddr),
    .rdata_o (dst_rdata)
  );

  brob_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_src_ram (
    .clk_i   (clk_i),
    .we_i    (src_we),
    .waddr_i (src_waddr),
    .wdata_i (src_wdata),
    .re_i    (src_re),
    .raddr_i (src_raddr),
    .rdata_o (src_rdata)
  );

`ifndef SYNTHESIS
  // write-back only trails a blit read
  a_bp_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bp_valid_q |-> (state_q == S_BLIT || state_q == S_RESULT))
    else $error("blit write-back outside a blit");

  // no command taken while the bitmaps are being cleared
  a_clear_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !s_axis_tready)
    else $error("command taken during clearing pass");

  // the blit never reads the pixel it is writing back
  a_dst_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dst_we && dst_re) |-> (dst_waddr != dst_raddr))
    else $error("read and write of one destination pixel in a cycle");

  // cell walk stays within its dots
  a_cell_k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CELL) |-> (k_q <= CELL_K_W'(CELL_DOTS)))
    else $error("cell walk overran");

  // blit walk stays inside the clipped rectangle
  a_blit_xy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BLIT) |-> (x_q >= x0_q && x_q < x1_q && y_q >= y0_q && y_q < y1_q))
    else $error("blit walk left the clipped area");
`endif

endmodule
